// File: rtl/core/multiframe_reassembly_slots_top_assert.svh
// ----------------------------------------------------------------------------
// Reassembly slot manager assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTIFRAME_REASSEMBLY_SLOTS_TOP_ASSERT_SVH
`define MULTIFRAME_REASSEMBLY_SLOTS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MFRS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mfrs assertion failed (same cycle)");
// next-cycle implication
`define MFRS_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mfrs assertion failed (next cycle)");
`else
`define MFRS_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define MFRS_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// File: rtl/core/mfrs_pkg.sv
// ----------------------------------------------------------------------------
// Reassembly slot manager package
// Sizes, codes, register map and shared types of the slot manager.
// ----------------------------------------------------------------------------
package mfrs_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int TEXT_CAP  = 512;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OCC_W     = $clog2(NUM_SLOTS + 1);
    localparam int TEXT_W    = $clog2(TEXT_CAP);
    localparam int ADD_W     = TEXT_W + 1;

    // stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 11;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 4;

    // APB
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [15:0] TOL_RESET      = 16'd250;
    localparam logic [31:0] TIMEOUT_RESET  = 32'd90000;
    localparam logic [7:0]  SUB_PLAIN_RST  = 8'd0;
    localparam logic [7:0]  SUB_COMP_RST   = 8'd1;

    typedef enum logic [1:0] {
        REG_FREQ_TOL  = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_SUB_PLAIN = 2'd2,
        REG_SUB_COMP  = 2'd3
    } mfrs_reg_t;

    typedef struct packed {
        logic [15:0] freq_tol;
        logic [31:0] timeout;
        logic [7:0]  sub_plain;
        logic [7:0]  sub_comp;
    } mfrs_cfg_t;

    // per-slot compare results of the scan evaluator
    typedef struct packed {
        logic expire;
        logic match;
        logic older;
    } mfrs_eval_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_PICK   = 4'b0100,
        ST_FINISH = 4'b1000
    } mfrs_state_t;

    typedef enum logic [2:0] {
        MODE_PASS   = 3'd0,
        MODE_TAIL   = 3'd1,
        MODE_OPEN   = 3'd2,
        MODE_APPEND = 3'd3,
        MODE_CLOSE  = 3'd4
    } mfrs_mode_t;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_SINGLE   = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_PARTIAL  = 2'd3;

    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_FRAME = 2'd1;
    localparam logic [1:0] SRC_SLOT  = 2'd2;

endpackage

// File: rtl/core/mfrs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Reassembly slot manager configuration registers
// APB register file: tolerance, timeout and the two data subtypes.
// ----------------------------------------------------------------------------
module mfrs_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mfrs_pkg::ADDR_W-1:0] paddr,
    input  logic [mfrs_pkg::DATA_W-1:0] pwdata,
    output logic [mfrs_pkg::DATA_W-1:0] prdata,
    output mfrs_pkg::mfrs_cfg_t        cfg
);

    mfrs_pkg::mfrs_cfg_t cfg_reg;
    mfrs_pkg::mfrs_reg_t reg_sel;
    logic                wr_en;

    assign reg_sel = mfrs_pkg::mfrs_reg_t'(paddr[mfrs_pkg::ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_tol  <= mfrs_pkg::TOL_RESET;
            cfg_reg.timeout   <= mfrs_pkg::TIMEOUT_RESET;
            cfg_reg.sub_plain <= mfrs_pkg::SUB_PLAIN_RST;
            cfg_reg.sub_comp  <= mfrs_pkg::SUB_COMP_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mfrs_pkg::REG_FREQ_TOL:  cfg_reg.freq_tol  <= pwdata[15:0];
                mfrs_pkg::REG_TIMEOUT:   cfg_reg.timeout   <= pwdata[31:0];
                mfrs_pkg::REG_SUB_PLAIN: cfg_reg.sub_plain <= pwdata[7:0];
                mfrs_pkg::REG_SUB_COMP:  cfg_reg.sub_comp  <= pwdata[7:0];
                default:                 cfg_reg.freq_tol  <= cfg_reg.freq_tol;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mfrs_pkg::REG_FREQ_TOL:  prdata = {16'd0, cfg_reg.freq_tol};
            mfrs_pkg::REG_TIMEOUT:   prdata = cfg_reg.timeout;
            mfrs_pkg::REG_SUB_PLAIN: prdata = {24'd0, cfg_reg.sub_plain};
            mfrs_pkg::REG_SUB_COMP:  prdata = {24'd0, cfg_reg.sub_comp};
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/mfrs_slot_eval.sv
// ----------------------------------------------------------------------------
// Reassembly slot evaluator
// Compares one slot against the current frame: timeout, frequency match, age.
// ----------------------------------------------------------------------------
module mfrs_slot_eval (
    input  logic [31:0]          now_ms,
    input  logic [31:0]          timeout_ms,
    input  logic [15:0]          frame_freq,
    input  logic [15:0]          freq_tol,
    input  logic [15:0]          slot_freq,
    input  logic [31:0]          slot_time,
    input  logic [31:0]          best_time,
    output mfrs_pkg::mfrs_eval_t res
);

    logic [31:0] age;
    logic [15:0] diff;

    // wrapping age
    assign age  = now_ms - slot_time;
    assign diff = (frame_freq >= slot_freq) ? (frame_freq - slot_freq)
                                            : (slot_freq - frame_freq);

    assign res.expire = (age >= timeout_ms);
    assign res.match  = (diff <= freq_tol);
    assign res.older  = (slot_time < best_time);

endmodule

// File: rtl/core/multiframe_reassembly_slots_top.sv
// ----------------------------------------------------------------------------
// Multi-frame reassembly slot manager
// Tracks NUM_SLOTS reassembly slots keyed by carrier frequency.
// ----------------------------------------------------------------------------
// Each frame header request yields exactly one result request. A frame whose
// subtype matches neither data subtype register passes straight through as a
// single frame: after accept it goes to the finish state, which loads its
// result, and s_tready comes back once the state returns to idle. A data frame
// goes through the scan, pick and finish states. The shared slot evaluator
// visits the NUM_SLOTS slots in turn, one slot per cycle. In that one pass it
// ages out stale slots and finds the match, the first free slot and the oldest
// slot. Then the pick state chooses the target, and the finish state updates
// it and loads the output register. The finish state waits while the previous
// result is still in the output register and not taken, so output stalls hold
// the frame there. One frame is in work at a time. s_tready is high only
// between frames, while a finished result may still wait in the output
// register. The character text is not stored here: the result says which
// slot, where to write, how many characters, and what to emit. Registers sit
// at byte addresses 0, 4, 8, 12 (tolerance, timeout, plain subtype,
// compressed subtype). They may only be written while no frame is in work.
// ----------------------------------------------------------------------------
`include "multiframe_reassembly_slots_top_assert.svh"

module multiframe_reassembly_slots_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // frame header requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] freq_tenths, [25:16] text_length, [57:26] now_ms
    input  logic [mfrs_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] tx_type, [10:3] subtype code
    input  logic [mfrs_pkg::S_TUSER_W-1:0] s_tuser,
    // result requests
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] slot_index, [11:3] write_offset, [20:12] write_count,
    // [29:21] emit_length, [45:30] message frames, [61:46] freq_out,
    // [62] evicted, [66:63] occupied
    output logic [mfrs_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] kind, [3:2] text_source
    output logic [mfrs_pkg::M_TUSER_W-1:0] m_tuser,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mfrs_pkg::ADDR_W-1:0]   paddr,
    input  logic [mfrs_pkg::DATA_W-1:0]   pwdata,
    output logic [mfrs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam logic [mfrs_pkg::SLOT_W-1:0] LAST_SLOT =
        mfrs_pkg::SLOT_W'(mfrs_pkg::NUM_SLOTS - 1);

    mfrs_pkg::mfrs_cfg_t  cfg;
    mfrs_pkg::mfrs_eval_t ev;

    // input unpack
    logic [15:0] s_freq;
    logic [9:0]  s_len;
    logic [31:0] s_now;
    logic [2:0]  s_tx;
    logic [7:0]  s_sub;
    logic        s_is_data;

    // control
    mfrs_pkg::mfrs_state_t          state_reg, state_next;
    mfrs_pkg::mfrs_mode_t           mode_reg, mode_next;
    logic [mfrs_pkg::SLOT_W-1:0]    idx_reg, idx_next;
    logic                           hit_found_reg, hit_found_next;
    logic                           free_found_reg, free_found_next;
    logic                           do_begin_reg, do_begin_next;
    logic                           evict_reg, evict_next;
    logic [mfrs_pkg::OCC_W-1:0]     occ_reg, occ_next;
    logic [mfrs_pkg::NUM_SLOTS-1:0] slot_in_use_reg, slot_in_use_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    // scan results
    logic [mfrs_pkg::SLOT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [mfrs_pkg::SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic [mfrs_pkg::SLOT_W-1:0]    oldest_idx_reg, oldest_idx_next;
    logic [31:0]                    oldest_time_reg, oldest_time_next;

    // latched frame header
    logic [15:0] in_freq_reg;
    logic [9:0]  in_len_reg;
    logic [31:0] in_now_reg;
    logic        in_first_reg;
    logic        in_last_reg;

    // slot state
    logic                         slot_saw_first_reg [mfrs_pkg::NUM_SLOTS];
    logic [15:0]                  slot_freq_reg      [mfrs_pkg::NUM_SLOTS];
    logic [15:0]                  slot_frames_reg    [mfrs_pkg::NUM_SLOTS];
    logic [mfrs_pkg::TEXT_W-1:0]  slot_text_len_reg  [mfrs_pkg::NUM_SLOTS];
    logic [31:0]                  slot_last_time_reg [mfrs_pkg::NUM_SLOTS];

    // output register
    logic [mfrs_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [mfrs_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic load_in;
    logic slot_wr;
    logic out_free;
    logic out_load;
    logic slot_live;

    // slot update arithmetic
    logic [mfrs_pkg::TEXT_W-1:0] base_len;
    logic [15:0]                 base_frames;
    logic [mfrs_pkg::ADD_W-1:0]  add_len;
    logic [mfrs_pkg::TEXT_W-1:0] room;
    logic [mfrs_pkg::TEXT_W-1:0] wr_cnt;
    logic [mfrs_pkg::TEXT_W-1:0] new_len;
    logic [15:0]                 new_frames;
    logic [mfrs_pkg::TEXT_W-1:0] direct_len;

    // result fields
    logic [1:0]  r_kind;
    logic [1:0]  r_src;
    logic [2:0]  r_slot;
    logic [8:0]  r_woff;
    logic [8:0]  r_wcnt;
    logic [8:0]  r_emit;
    logic [15:0] r_frames;
    logic [15:0] r_freq;
    logic        r_evict;

    assign s_freq = s_tdata[15:0];
    assign s_len  = s_tdata[25:16];
    assign s_now  = s_tdata[57:26];
    assign s_tx   = s_tuser[2:0];
    assign s_sub  = s_tuser[10:3];
    assign s_is_data = (s_sub == cfg.sub_plain) || (s_sub == cfg.sub_comp);

    assign s_tready = (state_reg == mfrs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;

    assign out_free = !m_tvalid_reg || m_tready;

    mfrs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // shared evaluator, always looking at slot idx_reg
    mfrs_slot_eval u_eval (
        .now_ms     (in_now_reg),
        .timeout_ms (cfg.timeout),
        .frame_freq (in_freq_reg),
        .freq_tol   (cfg.freq_tol),
        .slot_freq  (slot_freq_reg[idx_reg]),
        .slot_time  (slot_last_time_reg[idx_reg]),
        .best_time  (oldest_time_reg),
        .res        (ev)
    );

    // still in use after aging
    assign slot_live = slot_in_use_reg[idx_reg] && !ev.expire;

    // text bookkeeping for the target slot; a new slot starts empty
    assign base_len    = do_begin_reg ? '0 : slot_text_len_reg[idx_reg];
    assign base_frames = do_begin_reg ? '0 : slot_frames_reg[idx_reg];
    assign add_len     = (in_len_reg < mfrs_pkg::TEXT_CAP) ?
                         mfrs_pkg::ADD_W'(in_len_reg) : mfrs_pkg::ADD_W'(mfrs_pkg::TEXT_CAP);
    assign room        = mfrs_pkg::TEXT_W'(mfrs_pkg::TEXT_CAP - 1) - base_len;
    assign wr_cnt      = (add_len < mfrs_pkg::ADD_W'(room)) ?
                         mfrs_pkg::TEXT_W'(add_len) : room;
    assign new_len     = base_len + wr_cnt;
    assign new_frames  = base_frames + 16'd1;
    assign direct_len  = (in_len_reg < (mfrs_pkg::TEXT_CAP - 1)) ?
                         mfrs_pkg::TEXT_W'(in_len_reg) : mfrs_pkg::TEXT_W'(mfrs_pkg::TEXT_CAP - 1);

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        idx_next         = idx_reg;
        hit_found_next   = hit_found_reg;
        free_found_next  = free_found_reg;
        do_begin_next    = do_begin_reg;
        evict_next       = evict_reg;
        occ_next         = occ_reg;
        slot_in_use_next = slot_in_use_reg;
        hit_idx_next     = hit_idx_reg;
        free_idx_next    = free_idx_reg;
        oldest_idx_next  = oldest_idx_reg;
        oldest_time_next = oldest_time_reg;
        load_in          = 1'b0;
        slot_wr          = 1'b0;
        out_load         = 1'b0;

        unique case (state_reg)
            mfrs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    load_in         = 1'b1;
                    idx_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    do_begin_next   = 1'b0;
                    evict_next      = 1'b0;
                    mode_next       = mfrs_pkg::MODE_PASS;
                    state_next      = s_is_data ? mfrs_pkg::ST_SCAN : mfrs_pkg::ST_FINISH;
                end
            end

            mfrs_pkg::ST_SCAN:
            begin
                // age out, then look up / look for room
                if (slot_in_use_reg[idx_reg] && ev.expire)
                begin
                    slot_in_use_next[idx_reg] = 1'b0;
                    occ_next = occ_reg - mfrs_pkg::OCC_W'(1);
                end
                if (slot_live && ev.match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx_reg;
                end
                if (!slot_live && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                // oldest only matters when every slot is live; ties keep lower index
                if (idx_reg == '0)
                begin
                    oldest_idx_next  = '0;
                    oldest_time_next = slot_last_time_reg[idx_reg];
                end
                else if (slot_live && ev.older)
                begin
                    oldest_idx_next  = idx_reg;
                    oldest_time_next = slot_last_time_reg[idx_reg];
                end
                if (idx_reg == LAST_SLOT)
                    state_next = mfrs_pkg::ST_PICK;
                else
                    idx_next = idx_reg + mfrs_pkg::SLOT_W'(1);
            end

            mfrs_pkg::ST_PICK:
            begin
                state_next = mfrs_pkg::ST_FINISH;
                if (in_first_reg && in_last_reg)
                    mode_next = mfrs_pkg::MODE_PASS;
                else if (in_last_reg)
                begin
                    mode_next = hit_found_reg ? mfrs_pkg::MODE_CLOSE : mfrs_pkg::MODE_TAIL;
                    idx_next  = hit_idx_reg;
                end
                else
                begin
                    mode_next = in_first_reg ? mfrs_pkg::MODE_OPEN : mfrs_pkg::MODE_APPEND;
                    // a first frame restarts even a matching slot
                    do_begin_next = in_first_reg || !hit_found_reg;
                    if (hit_found_reg)
                        idx_next = hit_idx_reg;
                    else if (free_found_reg)
                        idx_next = free_idx_reg;
                    else
                    begin
                        idx_next   = oldest_idx_reg;
                        evict_next = 1'b1;
                    end
                end
            end

            mfrs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = mfrs_pkg::ST_IDLE;
                    case (mode_reg) inside
                        mfrs_pkg::MODE_OPEN, mfrs_pkg::MODE_APPEND:
                        begin
                            slot_wr = 1'b1;
                            slot_in_use_next[idx_reg] = 1'b1;
                            if (!slot_in_use_reg[idx_reg])
                                occ_next = occ_reg + mfrs_pkg::OCC_W'(1);
                        end
                        mfrs_pkg::MODE_CLOSE:
                        begin
                            slot_in_use_next[idx_reg] = 1'b0;
                            occ_next = occ_reg - mfrs_pkg::OCC_W'(1);
                        end
                        default:
                        begin
                            slot_wr = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = mfrs_pkg::ST_IDLE;
            end
        endcase
    end

    // result fields
    always_comb
    begin
        r_kind   = mfrs_pkg::KIND_NONE;
        r_src    = mfrs_pkg::SRC_NONE;
        r_slot   = '0;
        r_woff   = '0;
        r_wcnt   = '0;
        r_emit   = '0;
        r_frames = '0;
        r_freq   = '0;
        r_evict  = 1'b0;
        case (mode_reg) inside
            mfrs_pkg::MODE_PASS, mfrs_pkg::MODE_TAIL:
            begin
                r_kind   = (mode_reg == mfrs_pkg::MODE_PASS) ?
                           mfrs_pkg::KIND_SINGLE : mfrs_pkg::KIND_PARTIAL;
                r_src    = mfrs_pkg::SRC_FRAME;
                r_emit   = 9'(direct_len);
                r_frames = 16'd1;
                r_freq   = in_freq_reg;
            end
            mfrs_pkg::MODE_OPEN, mfrs_pkg::MODE_APPEND:
            begin
                r_slot  = 3'(idx_reg);
                r_woff  = 9'(base_len);
                r_wcnt  = 9'(wr_cnt);
                r_evict = evict_reg;
            end
            mfrs_pkg::MODE_CLOSE:
            begin
                r_slot   = 3'(idx_reg);
                r_woff   = 9'(base_len);
                r_wcnt   = 9'(wr_cnt);
                r_kind   = slot_saw_first_reg[idx_reg] ?
                           mfrs_pkg::KIND_COMPLETE : mfrs_pkg::KIND_PARTIAL;
                r_src    = mfrs_pkg::SRC_SLOT;
                r_emit   = 9'(new_len);
                r_frames = new_frames;
                r_freq   = slot_freq_reg[idx_reg];
            end
            default:
            begin
                r_kind = mfrs_pkg::KIND_NONE;
            end
        endcase
    end

    assign m_tdata_next = {5'd0, 4'(occ_next), r_evict, r_freq, r_frames,
                           r_emit, r_wcnt, r_woff, r_slot};
    assign m_tuser_next = {r_src, r_kind};

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mfrs_pkg::ST_IDLE;
            mode_reg        <= mfrs_pkg::MODE_PASS;
            idx_reg         <= '0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            do_begin_reg    <= 1'b0;
            evict_reg       <= 1'b0;
            occ_reg         <= '0;
            slot_in_use_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            idx_reg         <= idx_next;
            hit_found_reg   <= hit_found_next;
            free_found_reg  <= free_found_next;
            do_begin_reg    <= do_begin_next;
            evict_reg       <= evict_next;
            occ_reg         <= occ_next;
            slot_in_use_reg <= slot_in_use_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        oldest_idx_reg  <= oldest_idx_next;
        oldest_time_reg <= oldest_time_next;
        if (load_in)
        begin
            in_freq_reg  <= s_freq;
            in_len_reg   <= s_len;
            in_now_reg   <= s_now;
            in_first_reg <= s_tx[0];
            in_last_reg  <= s_tx[1];
        end
        if (out_load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
        if (slot_wr)
        begin
            if (do_begin_reg)
            begin
                slot_saw_first_reg[idx_reg] <= in_first_reg;
                slot_freq_reg[idx_reg]      <= in_freq_reg;
            end
            slot_text_len_reg[idx_reg]  <= new_len;
            slot_frames_reg[idx_reg]    <= new_frames;
            slot_last_time_reg[idx_reg] <= in_now_reg;
        end
    end

    // checks
    `MFRS_ASSERT_IMP(a_occ_count, clk, rst_n, 1'b1, occ_reg == $countones(slot_in_use_reg))
    `MFRS_ASSERT_NXT(a_scan_end, clk, rst_n, (state_reg == mfrs_pkg::ST_SCAN) && (idx_reg == LAST_SLOT), state_reg == mfrs_pkg::ST_PICK)
    `MFRS_ASSERT_NXT(a_finish_out, clk, rst_n, (state_reg == mfrs_pkg::ST_FINISH) && out_free, m_tvalid_reg && (state_reg == mfrs_pkg::ST_IDLE))
    `MFRS_ASSERT_NXT(a_close_frees, clk, rst_n, (state_reg == mfrs_pkg::ST_FINISH) && out_free && (mode_reg == mfrs_pkg::MODE_CLOSE), !slot_in_use_reg[$past(idx_reg)])

endmodule
